/* rtl/dbps_pkg.sv */
// ----------------------------------------------------------------------------
// dbps_pkg
// Shared types, constants and the correction table builder for the binned
// dB power sum block.
// ----------------------------------------------------------------------------
package dbps_pkg;

   localparam int FREQ_W     = 27;
   localparam int FREQ_OUT_W = 28;
   localparam int OFFS_W     = 10;
   localparam int LEVEL_W    = 16;
   localparam int NBINS_W    = 11;
   localparam int OP_W       = 2;
   localparam int RBIN_W     = 10;

   localparam int BINS_DEF         = 1024;
   localparam int CORR_ENTRIES_DEF = 256;

   // correction step is 16 LSB of 1/128 dB
   localparam int CORR_STEP_SHIFT = 4;
   localparam int ABS_DIFF_W      = 16;
   localparam int CIDX_W          = ABS_DIFF_W - CORR_STEP_SHIFT;
   localparam int CORR_VAL_W      = 9;

   localparam logic [FREQ_OUT_W-1:0] FREQ_MAX = '1;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_BASE_FREQ    = 2'd0;
   localparam logic [1:0] REG_FREQ_SPACING = 2'd1;
   localparam logic [1:0] REG_NUM_BINS     = 2'd2;

   localparam logic [FREQ_W-1:0]  BASE_FREQ_RST    = '0;
   localparam logic [FREQ_W-1:0]  FREQ_SPACING_RST = FREQ_W'(1);
   localparam logic [NBINS_W-1:0] NUM_BINS_RST     = NBINS_W'(1024);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ACC   = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_BIN,
      ST_CHECK,
      ST_FETCH,
      ST_LOOKUP,
      ST_MERGE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [FREQ_W-1:0]  base_freq;
      logic [FREQ_W-1:0]  freq_spacing;
      logic [NBINS_W-1:0] num_bins;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [FREQ_W-1:0] dividend;
      logic [FREQ_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [FREQ_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_v;
      v     = v_in;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (v >= res + bit_v) begin
            v   = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 10log10(1+10^(-d/1280)) in 1/128 dB, fixed-point build
   function automatic logic [CORR_VAL_W-1:0] corr_entry(input logic [63:0] d);
      logic [63:0] q30;
      logic [63:0] xq;
      logic [63:0] n;
      logic [63:0] f;
      logic [63:0] s;
      logic [63:0] p;
      logic [63:0] y;
      logic [63:0] z;
      logic [63:0] lg;
      logic [63:0] rem;
      logic [63:0] full;
      q30 = 64'd1 << 30;
      xq  = (d * 64'd217706 + 64'd640) / 64'd1280;
      n   = xq >> 16;
      f   = xq & 64'hFFFF;
      s   = 2 * q30;
      p   = q30;
      for (int k = 1; k <= 16; k++) begin
         s = isqrt64(s << 30);
         if (f[16-k]) begin
            p = (p * s) >> 30;
         end
      end
      // floor(2^60 / p), bit by bit
      rem = '0;
      y   = '0;
      for (int k = 60; k >= 0; k--) begin
         rem = (rem << 1) | ((k == 60) ? 64'd1 : 64'd0);
         if (rem >= p) begin
            rem = rem - p;
            y   = y | (64'd1 << k);
         end
      end
      y  = (n < 64'd40) ? (y >> n) : 64'd0;
      z  = q30 + y;
      lg = '0;
      if (z >= 2 * q30) begin
         lg = 64'd1 << 20;
      end else begin
         for (int k = 19; k >= 0; k--) begin
            z = (z * z) >> 30;
            if (z >= 2 * q30) begin
               lg = lg | (64'd1 << k);
               z  = z >> 1;
            end
         end
      end
      full = (lg * 64'd25252226 + (64'd1 << 35)) >> 36;
      return full[CORR_VAL_W-1:0];
   endfunction

endpackage

/* rtl/dbps_ram.sv */
// ----------------------------------------------------------------------------
// dbps_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module dbps_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dbps_div.sv */
// ----------------------------------------------------------------------------
// dbps_div
// Restoring divider, one quotient bit per cycle, for the bin index.
// ----------------------------------------------------------------------------
module dbps_div (
   input  logic                  clock,
   input  logic                  reset,
   input  dbps_pkg::div_req_type div_req,
   output dbps_pkg::div_rsp_type div_rsp
);

   import dbps_pkg::*;

   localparam int CNT_W = $clog2(FREQ_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [FREQ_W-1:0] rem_ff, rem_in;
   logic [FREQ_W-1:0] quo_ff, quo_in;
   logic [FREQ_W-1:0] dvs_ff, dvs_in;

   logic [FREQ_W:0]   shifted;
   logic [FREQ_W:0]   trial;
   logic              ge;

   assign shifted = {rem_ff, quo_ff[FREQ_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign ge      = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FREQ_W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? trial[FREQ_W-1:0] : shifted[FREQ_W-1:0];
         quo_in = {quo_ff[FREQ_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* rtl/dbps_corr_rom.sv */
// ----------------------------------------------------------------------------
// dbps_corr_rom
// Power sum correction table, built at elaboration, registered output.
// ----------------------------------------------------------------------------
module dbps_corr_rom #(
   parameter int CORR_ENTRIES = dbps_pkg::CORR_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic [dbps_pkg::CIDX_W-1:0]     idx,
   output logic [dbps_pkg::CORR_VAL_W-1:0] corr
);

   import dbps_pkg::*;

   localparam int CORR_W = $clog2(CORR_ENTRIES);

   logic [CORR_VAL_W-1:0] rom [CORR_ENTRIES];
   logic [CORR_VAL_W-1:0] corr_ff;
   logic                  in_range;

   for (genvar g = 0; g < CORR_ENTRIES; g++) begin : g_rom
      localparam logic [CORR_VAL_W-1:0] ENTRY = corr_entry(64'(g) << CORR_STEP_SHIFT);
      assign rom[g] = ENTRY;
   end

   assign in_range = ({1'b0, idx} < (CIDX_W + 1)'(CORR_ENTRIES));

   always_ff @(posedge clock) begin
      corr_ff <= in_range ? rom[idx[CORR_W-1:0]] : '0;
   end

   assign corr = corr_ff;

endmodule

/* rtl/dbps_csr.sv */
// ----------------------------------------------------------------------------
// dbps_csr
// APB-style configuration registers: base frequency, spacing, bin count.
// ----------------------------------------------------------------------------
module dbps_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dbps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dbps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dbps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output dbps_pkg::cfg_type             cfg
);

   import dbps_pkg::*;

   logic [FREQ_W-1:0]  base_ff, base_in;
   logic [FREQ_W-1:0]  spacing_ff, spacing_in;
   logic [NBINS_W-1:0] nbins_ff, nbins_in;
   logic               wr;
   logic [1:0]         reg_idx;

   assign wr      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx = csr_paddr[3:2];

   always_comb begin
      base_in    = base_ff;
      spacing_in = spacing_ff;
      nbins_in   = nbins_ff;
      if (wr) begin
         case (reg_idx)
            REG_BASE_FREQ:    base_in    = csr_pwdata[FREQ_W-1:0];
            REG_FREQ_SPACING: spacing_in = csr_pwdata[FREQ_W-1:0];
            REG_NUM_BINS:     nbins_in   = csr_pwdata[NBINS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BASE_FREQ:    csr_prdata = CSR_DATA_W'(base_ff);
         REG_FREQ_SPACING: csr_prdata = CSR_DATA_W'(spacing_ff);
         REG_NUM_BINS:     csr_prdata = CSR_DATA_W'(nbins_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= BASE_FREQ_RST;
         spacing_ff <= FREQ_SPACING_RST;
         nbins_ff   <= NUM_BINS_RST;
      end else begin
         base_ff    <= base_in;
         spacing_ff <= spacing_in;
         nbins_ff   <= nbins_in;
      end
   end

   assign csr_pready       = 1'b1;
   assign cfg.base_freq    = base_ff;
   assign cfg.freq_spacing = spacing_ff;
   assign cfg.num_bins     = nbins_ff;

endmodule

/* rtl/db_power_sum_bins.sv */
// ----------------------------------------------------------------------------
// db_power_sum_bins
// Frequency-binned power plot, samples combined as power sums in dB.
// ----------------------------------------------------------------------------
// Request beats (req_*) carry an op: clear all bins, accumulate one envelope
// sample, or read one bin. Every request gives exactly one response beat
// (rsp_*) with the bin level, bin frequency, empty flag and range flag.
// Configuration (base frequency, spacing, bin count) goes through the csr_
// port; the user must write it only while the block is idle, which the block
// itself does not enforce. One request at a time; req_stall is high while a
// request is in work. An accumulate forms the bin index with the 27-step
// restoring divider, followed by a read-modify-write of the bin memory
// through the correction table; a sample below base skips the divider, one
// out of range skips the memory, and an empty bin is written without the table.
// A read checks the range and fetches the bin; a no-op goes straight to its
// response. Clear sweeps the bin memory one entry per cycle. The next request
// can be taken in the cycle after the response is loaded.
// After reset the same sweep runs with req_stall high.
// The response sits in an output register; the next request is taken while
// it waits, and a new result waits until rsp_stall drops.
// ----------------------------------------------------------------------------
module db_power_sum_bins #(
   parameter int BINS         = dbps_pkg::BINS_DEF,
   parameter int CORR_ENTRIES = dbps_pkg::CORR_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dbps_pkg::OP_W-1:0]            req_op,
   input  logic [dbps_pkg::FREQ_W-1:0]          req_link_start_freq,
   input  logic [dbps_pkg::OFFS_W-1:0]          req_sample_offset,
   input  logic signed [dbps_pkg::LEVEL_W-1:0]  req_level_db,
   input  logic [dbps_pkg::RBIN_W-1:0]          req_read_bin,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [dbps_pkg::LEVEL_W-1:0]  rsp_sum_db,
   output logic [dbps_pkg::FREQ_OUT_W-1:0]      rsp_bin_freq,
   output logic                                 rsp_bin_empty,
   output logic                                 rsp_out_of_range,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dbps_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dbps_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dbps_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   import dbps_pkg::*;

   localparam int BIN_W   = $clog2(BINS);
   localparam int RAM_W   = LEVEL_W + 1;
   localparam int PROD_W  = NBINS_W + FREQ_W;
   localparam int FSUM_W  = PROD_W + 1;
   localparam int LDIFF_W = LEVEL_W + 2;

   localparam logic signed [LDIFF_W-1:0] SUM_MAX = LDIFF_W'(32767);
   localparam logic signed [LEVEL_W-1:0] LEVEL_SAT = 16'sh7FFF;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic [OFFS_W-1:0]          offs_ff, offs_in;
   logic signed [LEVEL_W-1:0]  lvl_ff, lvl_in;
   logic [FREQ_OUT_W-1:0]      bin_ff, bin_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic signed [LEVEL_W-1:0]  hi_ff, hi_in;
   logic [CIDX_W-1:0]          idx_ff, idx_in;
   logic [BIN_W-1:0]           clr_addr_ff, clr_addr_in;

   logic signed [LEVEL_W-1:0]  res_sum_ff, res_sum_in;
   logic [FREQ_OUT_W-1:0]      res_freq_ff, res_freq_in;
   logic                       res_empty_ff, res_empty_in;
   logic                       res_oor_ff, res_oor_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic [FREQ_OUT_W-1:0]      rsp_freq_ff, rsp_freq_in;
   logic                       rsp_empty_ff, rsp_empty_in;
   logic                       rsp_oor_ff, rsp_oor_in;

   logic                       ram_wr_en;
   logic [BIN_W-1:0]           ram_wr_addr;
   logic [RAM_W-1:0]           ram_wr_data;
   logic                       ram_rd_en;
   logic [RAM_W-1:0]           ram_rd_data;
   logic                       ram_valid;
   logic signed [LEVEL_W-1:0]  ram_level;

   logic [CORR_VAL_W-1:0]      corr_val;
   logic [FREQ_W-1:0]          sp_eff;
   logic [FREQ_OUT_W-1:0]      nb;
   logic [FSUM_W-1:0]          freq_sum;
   logic [FREQ_OUT_W-1:0]      freq_sat;
   logic signed [LDIFF_W-1:0]  lvl_diff;
   logic [LDIFF_W-1:0]         abs_diff;
   logic signed [LEVEL_W-1:0]  hi_val;
   logic signed [LDIFF_W-1:0]  merge_sum;
   logic signed [LDIFF_W-1:0]  corr_ext;
   logic signed [LEVEL_W-1:0]  merged;
   logic                       accept;
   logic                       rsp_load;
   op_type                     req_op_t;

   dbps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dbps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dbps_corr_rom #(
      .CORR_ENTRIES (CORR_ENTRIES)
   ) u_corr_rom (
      .clock (clock),
      .idx   (idx_ff),
      .corr  (corr_val)
   );

   dbps_ram #(
      .WIDTH (RAM_W),
      .DEPTH (BINS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (bin_ff[BIN_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_op_t  = op_type'(req_op);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   assign sp_eff = (cfg.freq_spacing == '0) ? FREQ_W'(1) : cfg.freq_spacing;
   assign nb     = (FREQ_OUT_W'(cfg.num_bins) > FREQ_OUT_W'(BINS)) ?
                   FREQ_OUT_W'(BINS) : FREQ_OUT_W'(cfg.num_bins);

   assign freq_sum = FSUM_W'(cfg.base_freq) + FSUM_W'(prod_ff);
   assign freq_sat = (freq_sum > FSUM_W'(FREQ_MAX)) ? FREQ_MAX : freq_sum[FREQ_OUT_W-1:0];

   assign ram_valid = ram_rd_data[LEVEL_W];
   assign ram_level = ram_rd_data[LEVEL_W-1:0];
   assign lvl_diff  = LDIFF_W'(ram_level) - LDIFF_W'(lvl_ff);
   assign abs_diff  = lvl_diff[LDIFF_W-1] ? LDIFF_W'(-lvl_diff) : LDIFF_W'(lvl_diff);
   assign hi_val    = (ram_level > lvl_ff) ? ram_level : lvl_ff;

   assign corr_ext  = LDIFF_W'(corr_val);
   assign merge_sum = LDIFF_W'(hi_ff) + corr_ext;
   assign merged    = (merge_sum > SUM_MAX) ? LEVEL_SAT : merge_sum[LEVEL_W-1:0];

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      offs_in      = offs_ff;
      lvl_in       = lvl_ff;
      bin_in       = bin_ff;
      prod_in      = prod_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      clr_addr_in  = clr_addr_ff;
      res_sum_in   = res_sum_ff;
      res_freq_in  = res_freq_ff;
      res_empty_in = res_empty_ff;
      res_oor_in   = res_oor_ff;
      div_req      = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = bin_ff[BIN_W-1:0];
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + BIN_W'(1);
            if (clr_addr_ff == BIN_W'(BINS - 1)) begin
               state_in = (op_ff == OP_CLEAR) ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_op_t;
               offs_in = req_sample_offset;
               lvl_in  = req_level_db;
               case (req_op_t)
                  OP_CLEAR: begin
                     clr_addr_in  = '0;
                     res_sum_in   = '0;
                     res_freq_in  = '0;
                     res_empty_in = 1'b1;
                     res_oor_in   = 1'b0;
                     state_in     = ST_CLEAR;
                  end
                  OP_ACC: begin
                     if (req_link_start_freq < cfg.base_freq) begin
                        res_sum_in   = '0;
                        res_freq_in  = '0;
                        res_empty_in = 1'b1;
                        res_oor_in   = 1'b1;
                        state_in     = ST_DONE;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = req_link_start_freq - cfg.base_freq;
                        div_req.divisor  = sp_eff;
                        state_in         = ST_DIV;
                     end
                  end
                  OP_READ: begin
                     bin_in   = FREQ_OUT_W'(req_read_bin);
                     state_in = ST_CHECK;
                  end
                  default: begin
                     res_sum_in   = '0;
                     res_freq_in  = '0;
                     res_empty_in = 1'b0;
                     res_oor_in   = 1'b0;
                     state_in     = ST_DONE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_BIN;
            end
         end
         ST_BIN: begin
            bin_in   = FREQ_OUT_W'(div_rsp.quotient) + FREQ_OUT_W'(offs_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            prod_in = PROD_W'(bin_ff[NBINS_W-1:0]) * PROD_W'(sp_eff);
            if (bin_ff >= nb) begin
               res_sum_in   = '0;
               res_freq_in  = '0;
               res_empty_in = 1'b1;
               res_oor_in   = 1'b1;
               state_in     = ST_DONE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_FETCH;
            end
         end
         ST_FETCH: begin
            res_freq_in = freq_sat;
            res_oor_in  = 1'b0;
            if (op_ff == OP_READ) begin
               res_sum_in   = ram_valid ? ram_level : '0;
               res_empty_in = !ram_valid;
               state_in     = ST_DONE;
            end else if (!ram_valid) begin
               ram_wr_en    = 1'b1;
               ram_wr_data  = {1'b1, lvl_ff};
               res_sum_in   = lvl_ff;
               res_empty_in = 1'b0;
               state_in     = ST_DONE;
            end else begin
               hi_in    = hi_val;
               idx_in   = abs_diff[ABS_DIFF_W-1:CORR_STEP_SHIFT];
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            ram_wr_en    = 1'b1;
            ram_wr_data  = {1'b1, merged};
            res_sum_in   = merged;
            res_empty_in = 1'b0;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_sum_in   = rsp_load ? res_sum_ff   : rsp_sum_ff;
      rsp_freq_in  = rsp_load ? res_freq_ff  : rsp_freq_ff;
      rsp_empty_in = rsp_load ? res_empty_ff : rsp_empty_ff;
      rsp_oor_in   = rsp_load ? res_oor_ff   : rsp_oor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         op_ff        <= OP_NOP;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      offs_ff      <= offs_in;
      lvl_ff       <= lvl_in;
      bin_ff       <= bin_in;
      prod_ff      <= prod_in;
      hi_ff        <= hi_in;
      idx_ff       <= idx_in;
      res_sum_ff   <= res_sum_in;
      res_freq_ff  <= res_freq_in;
      res_empty_ff <= res_empty_in;
      res_oor_ff   <= res_oor_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_freq_ff  <= rsp_freq_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sum_db       = rsp_sum_ff;
   assign rsp_bin_freq     = rsp_freq_ff;
   assign rsp_bin_empty    = rsp_empty_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

/* test/db_power_sum_bins_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// db_power_sum_bins_tb
// Self-checking bench for the binned dB power sum block.
// ----------------------------------------------------------------------------
// A driver feeds request beats from a backlog queue; a monitor forms the
// expected response of every accepted request with a local model of the bin
// memory and the correction table, and compares each response beat against
// it. Stimulus is a directed opening followed by phases, each with its own
// base frequency, spacing and bin count written through the csr port while
// the block is idle. Most accumulates land on a small pool of bins with
// levels close together, so that power sums and saturation get exercised.
// Both channels idle and stall at random, with some phases kept calm.
// ----------------------------------------------------------------------------
module db_power_sum_bins_tb;
   import dbps_pkg::*;

   localparam int NBINS     = 1024;
   localparam int CORR_N    = 256;
   localparam int PHASES    = 12;
   localparam int PHASE_LEN = 127;
   localparam longint unsigned START_MAX = 64'd134217727;

   typedef struct {
      op_type             op;
      logic [26:0]        start;
      logic [9:0]         offs;
      logic signed [15:0] lvl;
      logic [9:0]         rbin;
   } req_item_type;

   typedef struct {
      logic signed [15:0] sum_db;
      logic [27:0]        bin_freq;
      logic               empty;
      logic               oor;
   } bin_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_op = OP_NOP;
   logic [26:0]         req_link_start_freq = '0;
   logic [9:0]          req_sample_offset = '0;
   logic signed [15:0]  req_level_db = '0;
   logic [9:0]          req_read_bin = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [15:0]  rsp_sum_db;
   logic [27:0]         rsp_bin_freq;
   logic                rsp_bin_empty;
   logic                rsp_out_of_range;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                csr_pready;

   db_power_sum_bins u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_link_start_freq(req_link_start_freq), .req_sample_offset(req_sample_offset),
      .req_level_db(req_level_db), .req_read_bin(req_read_bin),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sum_db(rsp_sum_db),
      .rsp_bin_freq(rsp_bin_freq), .rsp_bin_empty(rsp_bin_empty),
      .rsp_out_of_range(rsp_out_of_range),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // local copy of block state
   logic [26:0]        cfg_base  = '0;
   logic [26:0]        cfg_space = 27'd1;
   logic [10:0]        cfg_nbins = 11'd1024;
   logic signed [15:0] bin_lvl  [NBINS];
   bit                 bin_full [NBINS];
   int                 corr_db_tab [CORR_N];

   req_item_type   req_backlog [$];
   bin_report_type bin_reports_due [$];
   req_item_type   nxt_req;
   req_item_type   seen_req;
   bin_report_type got;
   bin_report_type want;
   int             n_bad = 0;
   int             gap_left = 0;
   int             hold_left = 0;
   bit             calm = 1'b0;

   function automatic longint unsigned root_floor(input longint unsigned v_in);
      longint unsigned v, res, b;
      v   = v_in;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // correction in 1/128 dB for a level difference d, same fixed-point recipe
   function automatic int corr_db(input longint unsigned d);
      longint unsigned xq, ip, fr, s, p, y, z, lg;
      xq = (d * 64'd217706 + 64'd640) / 64'd1280;
      ip = xq >> 16;
      fr = xq & 64'hFFFF;
      s  = 64'd2 << 30;
      p  = 64'd1 << 30;
      for (int k = 1; k <= 16; k++) begin
         s = root_floor(s << 30);
         if (fr[16-k]) p = (p * s) >> 30;
      end
      y  = (64'd1 << 60) / p;
      y  = (ip < 40) ? (y >> ip) : 64'd0;
      z  = (64'd1 << 30) + y;
      lg = 0;
      if (z >= (64'd2 << 30)) begin
         lg = 64'd1 << 20;
      end else begin
         for (int k = 19; k >= 0; k--) begin
            z = (z * z) >> 30;
            if (z >= (64'd2 << 30)) begin
               lg = lg | (64'd1 << k);
               z  = z >> 1;
            end
         end
      end
      return int'((lg * 64'd25252226 + (64'd1 << 35)) >> 36);
   endfunction

   function automatic int power_merge(input int a, input int b);
      int hi, df, r;
      hi = (a > b) ? a : b;
      df = (a > b) ? a - b : b - a;
      r  = hi + (((df >> 4) < CORR_N) ? corr_db_tab[df >> 4] : 0);
      return (r > 32767) ? 32767 : r;
   endfunction

   function automatic longint unsigned usable_count();
      return (cfg_nbins > NBINS) ? NBINS : cfg_nbins;
   endfunction

   function automatic longint unsigned eff_spacing();
      return (cfg_space == 0) ? 1 : cfg_space;
   endfunction

   function automatic logic [27:0] freq_at(input longint unsigned bin);
      longint unsigned f;
      f = cfg_base + bin * eff_spacing();
      return (f > 64'hFFFFFFF) ? 28'hFFFFFFF : f[27:0];
   endfunction

   // applies one request to the local bin memory, returns the response it gives
   function automatic bin_report_type binned_sum_outcome(input req_item_type it);
      bin_report_type  r;
      longint unsigned nb, bin, st;
      int              nv;
      r.sum_db   = '0;
      r.bin_freq = '0;
      r.empty    = 1'b0;
      r.oor      = 1'b0;
      nb = usable_count();
      st = it.start;
      case (it.op)
         OP_CLEAR: begin
            bin_full = '{default: 1'b0};
            r.empty  = 1'b1;
         end
         OP_ACC: begin
            bin = (st >= cfg_base) ? (st - cfg_base) / eff_spacing() + it.offs : 0;
            if (st < cfg_base || bin >= nb) begin
               r.empty = 1'b1;
               r.oor   = 1'b1;
            end else begin
               nv = bin_full[bin] ? power_merge(bin_lvl[bin], it.lvl) : int'(it.lvl);
               bin_lvl[bin]  = 16'(nv);
               bin_full[bin] = 1'b1;
               r.sum_db      = 16'(nv);
               r.bin_freq    = freq_at(bin);
            end
         end
         OP_READ: begin
            if (it.rbin >= nb) begin
               r.empty = 1'b1;
               r.oor   = 1'b1;
            end else begin
               r.bin_freq = freq_at(it.rbin);
               if (bin_full[it.rbin]) r.sum_db = bin_lvl[it.rbin];
               else r.empty = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int gap_len();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (req_backlog.size() != 0) begin
            nxt_req = req_backlog.pop_front();
            req_op              <= nxt_req.op;
            req_link_start_freq <= nxt_req.start;
            req_sample_offset   <= nxt_req.offs;
            req_level_db        <= nxt_req.lvl;
            req_read_bin        <= nxt_req.rbin;
            req_valid           <= 1'b1;
            gap_left <= (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!calm && $urandom_range(0, 9) < 3) begin
         rsp_stall <= 1'b1;
         hold_left <= gap_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: check response beats, predict accepted request beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.sum_db   = rsp_sum_db;
            got.bin_freq = rsp_bin_freq;
            got.empty    = rsp_bin_empty;
            got.oor      = rsp_out_of_range;
            if (bin_reports_due.size() == 0) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("%0t: response beat with none expected: sum %0d freq %0d", $realtime,
                           got.sum_db, got.bin_freq);
            end else begin
               want = bin_reports_due.pop_front();
               if (got.sum_db !== want.sum_db || got.bin_freq !== want.bin_freq ||
                   got.empty !== want.empty || got.oor !== want.oor) begin
                  n_bad++;
                  if (n_bad <= 10)
                     $display("%0t: mismatch sum %0d/%0d freq %0d/%0d empty %b/%b oor %b/%b",
                              $realtime, got.sum_db, want.sum_db, got.bin_freq, want.bin_freq,
                              got.empty, want.empty, got.oor, want.oor);
               end
            end
         end
         if (req_valid && !req_stall) begin
            seen_req.op    = op_type'(req_op);
            seen_req.start = req_link_start_freq;
            seen_req.offs  = req_sample_offset;
            seen_req.lvl   = req_level_db;
            seen_req.rbin  = req_read_bin;
            bin_reports_due.insert(bin_reports_due.size(), binned_sum_outcome(seen_req));
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_BASE_FREQ:    cfg_base  = data[26:0];
         REG_FREQ_SPACING: cfg_space = data[26:0];
         REG_NUM_BINS:     cfg_nbins = data[10:0];
         default: ;
      endcase
   endtask

   task automatic queue_item(input op_type op, input logic [26:0] st, input logic [9:0] of,
                             input int lv, input logic [9:0] rb);
      req_item_type it;
      it.op    = op;
      it.start = st;
      it.offs  = of;
      it.lvl   = 16'(lv);
      it.rbin  = rb;
      req_backlog.insert(req_backlog.size(), it);
   endtask

   task automatic queue_noise(input op_type op);
      queue_item(op, 27'($urandom), 10'($urandom), int'($urandom), 10'($urandom));
   endtask

   task automatic drain();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || bin_reports_due.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic fill_phase(input int n_items, input int anchor);
      longint unsigned nb, sp, t, k, st, span, pool;
      int              lv, sel, clr_at;
      nb     = usable_count();
      sp     = eff_spacing();
      pool   = (nb < 16) ? nb : 16;
      clr_at = ($urandom_range(0, 9) < 6) ? $urandom_range(n_items / 3, n_items - 1) : -1;
      for (int i = 0; i < n_items; i++) begin
         sel = $urandom_range(0, 99);
         if (i == clr_at) begin
            queue_noise(OP_CLEAR);
         end else if (sel < 15 || nb == 0) begin
            queue_noise(op_type'($urandom_range(1, 3)));
         end else if (sel < 40) begin
            case ($urandom_range(0, 3))
               0: t = $urandom_range(0, 1023);
               1: t = nb - 1 + $urandom_range(0, 1);
               default: t = $urandom_range(0, 32'(pool - 1));
            endcase
            queue_item(OP_READ, 27'($urandom), 10'($urandom), int'($urandom), 10'(t));
         end else if (sel < 44 && cfg_base != 0) begin
            queue_item(OP_ACC, 27'($urandom_range(0, 32'(cfg_base - 1))), 10'($urandom),
                       int'($urandom), 10'($urandom));
         end else begin
            if ($urandom_range(0, 3) == 0) t = $urandom_range(0, 32'(nb - 1));
            else t = $urandom_range(0, 32'(pool - 1));
            k  = $urandom_range(0, 32'(t));
            st = cfg_base + k * sp;
            if (st > START_MAX) begin
               k  = 0;
               st = cfg_base;
            end
            span = START_MAX - st;
            if (span > sp - 1) span = sp - 1;
            st = st + $urandom_range(0, 32'(span));
            if ($urandom_range(0, 9) == 0) lv = $urandom_range(0, 1) ? 32767 : -32768;
            else lv = anchor + int'($urandom_range(0, 8400)) - 4200;
            if (lv > 32767) lv = 32767;
            if (lv < -32768) lv = -32768;
            queue_item(OP_ACC, 27'(st), 10'(t - k), lv, 10'($urandom));
         end
      end
   endtask

   initial begin
      logic [31:0] b, s, n;
      int          anchor;
      for (int i = 0; i < CORR_N; i++) corr_db_tab[i] = corr_db(i * 16);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock); while (req_stall);

      // directed opening, reset configuration
      queue_item(OP_READ, 0, 0, 0, 0);
      queue_item(OP_READ, 0, 0, 0, 1023);
      queue_item(OP_ACC, 0, 0, 32767, 0);
      queue_item(OP_ACC, 0, 0, 32767, 0);
      queue_item(OP_ACC, 1, 0, -32768, 0);
      queue_item(OP_ACC, 0, 1, 32767, 0);
      queue_item(OP_ACC, 2, 0, 0, 0);
      queue_item(OP_ACC, 2, 0, 4095, 0);
      queue_item(OP_ACC, 2, 0, 8200, 0);
      queue_item(OP_ACC, 3, 0, 100, 0);
      queue_item(OP_ACC, 3, 0, 100, 0);
      queue_item(OP_ACC, 1023, 0, -1, 0);
      queue_item(OP_ACC, 1023, 1, 7, 0);
      queue_item(OP_ACC, 27'h7FFFFFF, 10'h3FF, 5, 10'h3FF);
      queue_item(OP_READ, 0, 0, 0, 0);
      queue_item(OP_READ, 0, 0, 0, 1);
      queue_item(OP_READ, 0, 0, 0, 2);
      queue_item(OP_READ, 0, 0, 0, 1023);
      queue_item(OP_NOP, 27'h7FFFFFF, 10'h3FF, -1, 10'h3FF);
      queue_item(OP_CLEAR, 0, 0, 0, 0);
      queue_item(OP_READ, 0, 0, 0, 0);
      queue_item(OP_ACC, 0, 0, -5, 0);
      queue_item(OP_READ, 0, 0, 0, 0);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin b = 0; s = 1; n = 1024; end
            1: begin b = 1000; s = 0; n = 2047; end
            2: begin b = 32'h7FFFFFF; s = 7; n = 64; end
            3: begin b = $urandom_range(0, 1 << 20); s = 32'h7FFFFFF; n = 1024; end
            4: begin b = $urandom & 32'h7FFFFFF; s = $urandom_range(1, 1000); n = 1; end
            5: begin b = $urandom_range(0, 5000); s = 3; n = 0; end
            6: begin b = $urandom_range(0, 1 << 26); s = $urandom_range(1, 50); n = 1025; end
            default: begin
               b = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 100000)
                                               : $urandom & 32'h7FFFFFF;
               s = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 16)
                                               : $urandom_range(1, 32'h7FFFFFF);
               n = $urandom_range(1, 1024);
            end
         endcase
         csr_write(REG_BASE_FREQ, b);
         csr_write(REG_FREQ_SPACING, s);
         csr_write(REG_NUM_BINS, n);
         case ($urandom_range(0, 3))
            0: anchor = 0;
            1: anchor = 31500;
            2: anchor = -31500;
            default: anchor = int'($urandom_range(0, 60000)) - 30000;
         endcase
         @(negedge clock);
         calm = (ph % 4 == 2);
         fill_phase(PHASE_LEN, anchor);
         drain();
      end

      if (n_bad == 0 && bin_reports_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/dbps_pkg.sv
rtl/dbps_ram.sv
rtl/dbps_div.sv
rtl/dbps_corr_rom.sv
rtl/dbps_csr.sv
rtl/db_power_sum_bins.sv
test/db_power_sum_bins_tb.sv
